@@ rtl/core/lkvc_pkg.sv @@
// Shared types and constants for the LRU key/value cache core.
// No dependencies; imported by lkvc_cell and lru_key_value_cache_core.
package lkvc_pkg;

    localparam int KEY_W           = 32;
    localparam int VAL_W           = 32;
    localparam int CAP_W           = 5;
    localparam int STATUS_W        = 3;
    localparam int MAX_ENTRIES_DEF = 16;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    localparam logic REQ_SET = 1'b0;
    localparam logic REQ_GET = 1'b1;

    localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_EVICTED  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_PRESENT  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_HIT      = 3'd3;
    localparam logic [STATUS_W-1:0] ST_MISS     = 3'd4;

    localparam logic [VAL_W-1:0] MISS_VALUE = {VAL_W{1'b1}};

    // One cache entry as it moves down the recency chain
    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [VAL_W-1:0] value;
    } entry_t;

endpackage

@@ rtl/core/lkvc_cell.sv @@
// One recency slot of the LRU chain: holds an entry, compares it to the request key.
// Depends on lkvc_pkg.
module lkvc_cell
    import lkvc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             take,
    input  entry_t           upstream,
    input  logic [KEY_W-1:0] req_key,
    output entry_t           entry,
    output logic             match
);

    logic             valid_reg;
    logic [KEY_W-1:0] key_reg;
    logic [VAL_W-1:0] value_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (take)
        begin
            valid_reg <= upstream.valid;
        end
    end

    // Payload needs no reset: only valid slots are ever read
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            key_reg   <= upstream.key;
            value_reg <= upstream.value;
        end
    end

    assign entry.valid = valid_reg;
    assign entry.key   = key_reg;
    assign entry.value = value_reg;
    assign match       = valid_reg && (key_reg == req_key);

endmodule

@@ rtl/core/lru_key_value_cache_core.sv @@
// Top level of the fully associative LRU key/value cache.
// Depends on lkvc_pkg and lkvc_cell.
//
// Usage
//   Request channel: in_valid / in_stall with req_type (0 set, 1 get), key, value.
//   Result channel: out_valid / out_stall with status, read_value, evicted_key,
//   evicted_value. Every request item yields exactly one result item.
//   Configuration: cfg_we / cfg_wdata write the capacity register; write it only
//   while no request is in flight.
// Operation and throughput
//   A request is resolved in the cycle it is accepted: every cell compares its key
//   in parallel, the hit slot is found, and the chain shifts one place toward the
//   least recent end. The result item appears in the output register in the cycle
//   after acceptance. One item is taken per cycle while in_stall is low.
// Stall
//   While out_stall holds a waiting result, in_stall is raised and the result holds.
//   Once the result is taken, a new item may be accepted in the same cycle.
// Reset
//   rst_n clears all slot valid bits, occupancy and the output valid flag, and
//   returns capacity to 16. There is no clearing pass; the block is ready at once.
module lru_key_value_cache_core
    import lkvc_pkg::*;
#(
    parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CAP_W-1:0]    cfg_wdata,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                req_type,
    input  logic [KEY_W-1:0]    key,
    input  logic [VAL_W-1:0]    value,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [STATUS_W-1:0] status,
    output logic [VAL_W-1:0]    read_value,
    output logic [KEY_W-1:0]    evicted_key,
    output logic [VAL_W-1:0]    evicted_value
);

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int CW    = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    logic [CAP_W-1:0] capacity_reg;
    logic [CNT_W-1:0] occ_reg, occ_next;

    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [VAL_W-1:0]    read_value_reg, read_value_next;
    logic [KEY_W-1:0]    evicted_key_reg, evicted_key_next;
    logic [VAL_W-1:0]    evicted_value_reg, evicted_value_next;

    entry_t                 chain [MAX_ENTRIES+1];
    logic [MAX_ENTRIES-1:0] match_vec;
    logic [MAX_ENTRIES-1:0] take_vec;

    logic             accept;
    logic             hit;
    logic [IDX_W-1:0] hit_idx;
    logic [VAL_W-1:0] hit_value;
    logic [IDX_W-1:0] evict_idx;
    logic [KEY_W-1:0] tail_key;
    logic [VAL_W-1:0] tail_value;
    logic [CW-1:0]    cap_eff;
    logic             full;
    logic             update;
    logic [IDX_W-1:0] limit;

    // Hold new items back while a finished result is still waiting
    assign in_stall = out_valid_reg && out_stall;
    assign accept   = in_valid && !in_stall;

    // Keys are unique among valid slots, so at most one cell matches
    always_comb
    begin
        hit_idx    = '0;
        hit_value  = '0;
        tail_key   = '0;
        tail_value = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
        begin
            if (match_vec[i])
            begin
                hit_idx   = hit_idx | IDX_W'(i);
                hit_value = hit_value | chain[i+1].value;
            end
            if (evict_idx == IDX_W'(i))
            begin
                tail_key   = tail_key | chain[i+1].key;
                tail_value = tail_value | chain[i+1].value;
            end
        end
    end

    assign hit       = |match_vec;
    assign evict_idx = IDX_W'(occ_reg - CNT_W'(1));

    // Zero capacity acts as one, oversize capacity as the full chain
    always_comb
    begin
        if (capacity_reg == '0)
        begin
            cap_eff = CW'(1);
        end
        else if (CW'(capacity_reg) > CW'(MAX_ENTRIES))
        begin
            cap_eff = CW'(MAX_ENTRIES);
        end
        else
        begin
            cap_eff = CW'(capacity_reg);
        end
    end

    assign full = (CW'(occ_reg) >= cap_eff) && (occ_reg != '0);

    // Decide result and how far down the chain the shift reaches
    always_comb
    begin
        status_next        = ST_MISS;
        read_value_next    = '0;
        evicted_key_next   = '0;
        evicted_value_next = '0;
        update             = 1'b0;
        limit              = '0;
        occ_next           = occ_reg;
        if (req_type == REQ_SET)
        begin
            if (hit)
            begin
                status_next = ST_PRESENT;
            end
            else if (full)
            begin
                status_next        = ST_EVICTED;
                evicted_key_next   = tail_key;
                evicted_value_next = tail_value;
                update             = accept;
                limit              = evict_idx;
            end
            else
            begin
                // Occupancy is below the chain length here, so it fits the index
                status_next = ST_INSERTED;
                update      = accept;
                limit       = IDX_W'(occ_reg);
                if (accept)
                begin
                    occ_next = occ_reg + CNT_W'(1);
                end
            end
        end
        else
        begin
            if (hit)
            begin
                status_next     = ST_HIT;
                read_value_next = hit_value;
                update          = accept;
                limit           = hit_idx;
            end
            else
            begin
                status_next     = ST_MISS;
                read_value_next = MISS_VALUE;
            end
        end
    end

    // Head of the chain: the entry that becomes most recent
    assign chain[0].valid = 1'b1;
    assign chain[0].key   = key;
    assign chain[0].value = (req_type == REQ_GET) ? hit_value : value;

    genvar g;
    generate
        for (g = 0; g < MAX_ENTRIES; g++)
        begin : g_cell
            // Advance every slot up to the limit by one place
            assign take_vec[g] = update && (IDX_W'(g) <= limit);

            lkvc_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .take     (take_vec[g]),
                .upstream (chain[g]),
                .req_key  (key),
                .entry    (chain[g+1]),
                .match    (match_vec[g])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (cfg_we)
        begin
            capacity_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            occ_reg       <= occ_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Drop the result once taken, hold it while stalled
    assign out_valid_next = accept || (out_valid_reg && out_stall);

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg        <= status_next;
            read_value_reg    <= read_value_next;
            evicted_key_reg   <= evicted_key_next;
            evicted_value_reg <= evicted_value_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign read_value    = read_value_reg;
    assign evicted_key   = evicted_key_reg;
    assign evicted_value = evicted_value_reg;

    // Keys stay unique across the chain
    a_unique_match: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(match_vec))
    else $error("more than one cell matches the request key");

    // Occupancy stays within the chain, and a nonzero occupancy has a valid head slot
    a_valid_run: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(take_vec) <= MAX_ENTRIES &&
        (occ_reg == '0 || chain[1].valid) && CW'(occ_reg) <= CW'(MAX_ENTRIES))
    else $error("occupancy out of step with the cell chain");

    // An accepted item shows a result on the next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> out_valid_reg)
    else $error("accepted item produced no result");

endmodule

@@ tb/lru_cache_checker.sv @@
`timescale 1ns / 1ps
// Result checker for the LRU key/value cache core: mirrors the recency store,
// predicts each result item and compares it with what the core returns.
// Depends on lkvc_pkg for widths and status codes.
module lru_cache_checker
    import lkvc_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [CAP_W-1:0]    cfg_wdata,
    input  logic                in_valid,
    input  logic                in_stall,
    input  logic                req_type,
    input  logic [KEY_W-1:0]    key,
    input  logic [VAL_W-1:0]    value,
    input  logic                out_valid,
    input  logic                out_stall,
    input  logic [STATUS_W-1:0] status,
    input  logic [VAL_W-1:0]    read_value,
    input  logic [KEY_W-1:0]    evicted_key,
    input  logic [VAL_W-1:0]    evicted_value,
    output int                  outstanding,
    output int unsigned         mismatches
);

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [VAL_W-1:0]    read_value;
        logic [KEY_W-1:0]    evicted_key;
        logic [VAL_W-1:0]    evicted_value;
    } lookup_result_t;

    // Mirror of the store: slot 0 is the most recent entry
    logic [KEY_W-1:0] mirror_key   [MAX_ENTRIES_DEF];
    logic [VAL_W-1:0] mirror_value [MAX_ENTRIES_DEF];
    logic             mirror_valid [MAX_ENTRIES_DEF];
    int unsigned      fill;
    logic [CAP_W-1:0] capacity_reg;

    lookup_result_t pending_results[$];

    function automatic int unsigned active_capacity();
        if (capacity_reg == 0)
            return 1;
        if (capacity_reg > MAX_ENTRIES_DEF)
            return MAX_ENTRIES_DEF;
        return capacity_reg;
    endfunction

    // Move slots 0..n-1 one place toward the least recent end
    function automatic void age_slots(int unsigned n);
        int unsigned i;
        if (n >= MAX_ENTRIES_DEF)
            n = MAX_ENTRIES_DEF - 1;
        for (i = n; i > 0; i--)
        begin
            mirror_key[i]   = mirror_key[i-1];
            mirror_value[i] = mirror_value[i-1];
            mirror_valid[i] = mirror_valid[i-1];
        end
    endfunction

    function automatic void put_front(logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
        mirror_key[0]   = k;
        mirror_value[0] = v;
        mirror_valid[0] = 1'b1;
    endfunction

    function automatic void predict_lookup(logic rt, logic [KEY_W-1:0] k,
                                           logic [VAL_W-1:0] v);
        lookup_result_t res;
        int unsigned    pos;
        int unsigned    i;
        logic [VAL_W-1:0] hit_value;
        res = '0;
        pos = MAX_ENTRIES_DEF;
        for (i = 0; i < fill && i < MAX_ENTRIES_DEF; i++)
            if (pos == MAX_ENTRIES_DEF && mirror_valid[i] && mirror_key[i] == k)
                pos = i;
        if (rt == REQ_SET)
        begin
            if (pos < MAX_ENTRIES_DEF)
                res.status = ST_PRESENT;
            else if (fill >= active_capacity() && fill > 0)
            begin
                // Full (or over a lowered capacity): drop only the least recent
                res.status        = ST_EVICTED;
                res.evicted_key   = mirror_key[fill-1];
                res.evicted_value = mirror_value[fill-1];
                age_slots(fill - 1);
                put_front(k, v);
            end
            else
            begin
                res.status = ST_INSERTED;
                age_slots(fill);
                put_front(k, v);
                if (fill < MAX_ENTRIES_DEF)
                    fill++;
            end
        end
        else if (pos < MAX_ENTRIES_DEF)
        begin
            hit_value      = mirror_value[pos];
            res.status     = ST_HIT;
            res.read_value = hit_value;
            age_slots(pos);
            put_front(k, hit_value);
        end
        else
        begin
            res.status     = ST_MISS;
            res.read_value = MISS_VALUE;
        end
        pending_results.push_back(res);
    endfunction

    function automatic void compare_field(string name, logic [31:0] exp_v,
                                          logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            mismatches++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        lookup_result_t exp_res;
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_ENTRIES_DEF; i++)
            begin
                mirror_key[i]   = '0;
                mirror_value[i] = '0;
                mirror_valid[i] = 1'b0;
            end
            fill         = 0;
            capacity_reg = CAP_RESET;
            pending_results.delete();
            mismatches   = 0;
            outstanding <= 0;
        end
        else
        begin
            // Retire the result first: it belongs to an item taken earlier
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %h %h %h %h",
                             $time, status, read_value, evicted_key, evicted_value);
                    mismatches++;
                end
                else
                begin
                    exp_res = pending_results.pop_front();
                    compare_field("status", 32'(exp_res.status), 32'(status));
                    compare_field("read_value", exp_res.read_value, read_value);
                    compare_field("evicted_key", exp_res.evicted_key, evicted_key);
                    compare_field("evicted_value", exp_res.evicted_value, evicted_value);
                end
            end
            if (cfg_we)
                capacity_reg = cfg_wdata;
            if (in_valid && !in_stall)
                predict_lookup(req_type, key, value);
            outstanding <= pending_results.size();
        end
    end

endmodule

@@ tb/tb_lru_key_value_cache_core.sv @@
`timescale 1ns / 1ps
// Testbench top for the LRU key/value cache core: drives requests and capacity
// writes, stalls the result side, and gives the verdict from lru_cache_checker.
// Depends on lkvc_pkg, lru_key_value_cache_core and lru_cache_checker.
module tb_lru_key_value_cache_core
    import lkvc_pkg::*;
();

    localparam int   MAX_CYCLES = 200000;
    localparam int   NUM_PHASES = 10;
    localparam int   PHASE_ITEMS = 80;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [CAP_W-1:0]    cfg_wdata;
    logic                in_valid;
    logic                in_stall;
    logic                req_type;
    logic [KEY_W-1:0]    key;
    logic [VAL_W-1:0]    value;
    logic                out_valid;
    logic                out_stall;
    logic [STATUS_W-1:0] status;
    logic [VAL_W-1:0]    read_value;
    logic [KEY_W-1:0]    evicted_key;
    logic [VAL_W-1:0]    evicted_value;

    int                  outstanding;
    int unsigned         mismatches;
    int unsigned         cycle_count;
    // Set for the closing phase: no gaps on either side
    bit                  steady;

    logic [KEY_W-1:0]    key_pool[32];

    lru_key_value_cache_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .key           (key),
        .value         (value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .read_value    (read_value),
        .evicted_key   (evicted_key),
        .evicted_value (evicted_value)
    );

    lru_cache_checker lookup_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .req_type      (req_type),
        .key           (key),
        .value         (value),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .read_value    (read_value),
        .evicted_key   (evicted_key),
        .evicted_value (evicted_value),
        .outstanding   (outstanding),
        .mismatches    (mismatches)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    // Watchdog: end the run if the handshakes ever lock up
    initial
    begin
        cycle_count = 0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLES)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // Result side: in each burst, stall with a chance of one in three, else run free;
    // hold out_stall low once the closing phase starts.
    initial
    begin
        int burst;
        out_stall = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (steady)
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else
            begin
                burst = $urandom_range(1, 16);
                out_stall <= ($urandom_range(0, 2) == 0);
                repeat (burst) @(posedge clk);
            end
        end
    end

    // Present one item and hold it until the core takes it. The pre-edge value
    // of in_stall is read right after the edge, before any register updates.
    task automatic send_item(input logic rt, input logic [KEY_W-1:0] k,
                             input logic [VAL_W-1:0] v);
        in_valid <= 1'b1;
        req_type <= rt;
        key      <= k;
        value    <= v;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    // Drop valid and wait until every predicted result has been retired,
    // then let the pipeline settle.
    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (3) @(posedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] c);
        cfg_we    <= 1'b1;
        cfg_wdata <= c;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        int               gap_pct;
        int               pool_n;
        logic [CAP_W-1:0] cap_plan[NUM_PHASES];
        logic             rt;
        logic [KEY_W-1:0] k;

        steady    = 1'b0;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_wdata = '0;
        in_valid  = 1'b0;
        req_type  = REQ_SET;
        key       = '0;
        value     = '0;

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, capacity at its reset value of 16.
        // Get on an empty store misses.
        send_item(REQ_GET, 32'h0000_0000, 32'h0000_0000);
        // Extreme keys and values
        send_item(REQ_SET, 32'h8000_0000, 32'h7FFF_FFFF);
        send_item(REQ_SET, 32'h7FFF_FFFF, 32'h8000_0000);
        send_item(REQ_SET, 32'h0000_0000, 32'h0000_0000);
        send_item(REQ_SET, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // Hits ignore the value field; the second one moves the oldest entry up
        send_item(REQ_GET, 32'hFFFF_FFFF, $urandom());
        send_item(REQ_GET, 32'h8000_0000, 32'hFFFF_FFFF);
        // Set of a key already present changes nothing
        send_item(REQ_SET, 32'h0000_0000, 32'h1234_5678);
        send_item(REQ_GET, 32'h1234_5678, 32'h0000_0000);
        send_item(REQ_GET, 32'h0000_0000, 32'h5555_AAAA);
        drain();

        // Lower capacity below occupancy: each insert evicts just one entry
        write_capacity(5'd2);
        send_item(REQ_SET, 32'h0000_1111, 32'hAAAA_5555);
        send_item(REQ_SET, 32'h0000_2222, 32'h0F0F_0F0F);
        send_item(REQ_GET, 32'h8000_0000, 32'h0000_0000);
        send_item(REQ_SET, 32'h0000_3333, 32'hF0F0_F0F0);
        drain();

        // Capacity of zero behaves as one
        write_capacity(5'd0);
        send_item(REQ_SET, 32'h0000_4444, 32'h1111_2222);
        send_item(REQ_GET, 32'h0000_4444, 32'h0000_0000);
        drain();

        // Capacity above the store size behaves as 16: ten new keys all insert, none evict
        write_capacity(5'd31);
        for (int i = 0; i < 10; i++)
            send_item(REQ_SET, 32'h0001_0000 + i, $urandom());
        drain();

        // Random part: one capacity per phase, requests drawn mostly from a
        // small key pool so that hits, present keys and evictions are common.
        cap_plan = '{5'd16, 5'd1, 5'd8, 5'd0, 5'd31, 5'd17, 5'd3, 5'd2, 5'd12, 5'd16};
        cap_plan[6] = 5'($urandom_range(1, 16));
        cap_plan[8] = 5'($urandom());
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            write_capacity(cap_plan[phase]);
            pool_n = $urandom_range(2, 24);
            for (int i = 0; i < pool_n; i++)
                key_pool[i] = $urandom();
            if (phase == NUM_PHASES - 1)
            begin
                steady  = 1'b1;
                gap_pct = 0;
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0: gap_pct = 0;
                    1: gap_pct = 20;
                    default: gap_pct = 50;
                endcase
            end
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct)
                begin
                    in_valid <= 1'b0;
                    repeat ($urandom_range(1, 16)) @(posedge clk);
                end
                rt = $urandom_range(0, 1) ? REQ_GET : REQ_SET;
                if ($urandom_range(0, 99) < 88)
                    k = key_pool[$urandom_range(0, pool_n - 1)];
                else
                    k = $urandom();
                send_item(rt, k, $urandom());
            end
            drain();
        end

        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/lkvc_pkg.sv
rtl/core/lkvc_cell.sv
rtl/core/lru_key_value_cache_core.sv
tb/lru_cache_checker.sv
tb/tb_lru_key_value_cache_core.sv
